FILE: rtl/rgb_image_rle_row_encoder_macros.svh
// Assertion macros for the RLE row encoder.
`ifndef RGB_IMAGE_RLE_ROW_ENCODER_MACROS_SVH
`define RGB_IMAGE_RLE_ROW_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define RLE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("rle check failed");
`define RLE_ASSERT_NEVER(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error("rle check failed");
`else
`define RLE_ASSERT(lbl, clk, rst, prop)
`define RLE_ASSERT_NEVER(lbl, clk, rst, prop)
`endif
`endif

FILE: rtl/rgbrle_pkg.sv
// Shared constants and types of the RLE row encoder.
package rgbrle_pkg;
   localparam int DEFAULT_MAX_ROW_WIDTH = 65535;
   localparam int DEFAULT_WORD_BYTES    = 8;
   localparam int STORE_DEPTH           = 128;
   localparam int CHUNK_MAX             = 126;
   localparam logic [7:0] LIT_FLAG      = 8'h80;
   localparam int LUMA_R                = 79;
   localparam int LUMA_G                = 156;
   localparam int LUMA_B                = 21;
   localparam logic [17:0] TOTAL_MAX    = 18'h3FFFF;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;
   localparam logic [1:0] CH_LUMA  = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       final_byte;
   } byte_push_type;
endpackage

FILE: rtl/rgb_image_rle_row_encoder.sv
// A request is taken, classified in the next cycle, then the encoded bytes leave
// one per cycle while the packer accepts them: a literal flush of k bytes is a
// header byte and k stored bytes, run and tail codes up to five bytes more. A new
// request is taken only once all bytes of the last one have gone to the packer.
// Reset (synchronous, active high) clears the row state, packer and register;
// the literal store is not cleared and is only read where written in the row.
`include "rgb_image_rle_row_encoder_macros.svh"
module rgb_image_rle_row_encoder #(
   parameter int MAX_ROW_WIDTH = rgbrle_pkg::DEFAULT_MAX_ROW_WIDTH,
   parameter int WORD_BYTES    = rgbrle_pkg::DEFAULT_WORD_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_last_in_row,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_word,
   output logic [3:0]  rsp_out_bytes,
   output logic        rsp_row_end,
   output logic [17:0] rsp_row_bytes,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);
   localparam int RPW = $clog2(MAX_ROW_WIDTH + 1);
   localparam int AW  = $clog2(rgbrle_pkg::STORE_DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLASS = 3'd1;
   localparam logic [2:0] S_HDR   = 3'd2;
   localparam logic [2:0] S_DATA  = 3'd3;
   localparam logic [2:0] S_LIST  = 3'd4;

   localparam logic PH_LITERAL = 1'b0;
   localparam logic PH_RUN     = 1'b1;

   localparam logic [6:0] CHUNK = 7'(rgbrle_pkg::CHUNK_MAX);

   logic [2:0]     state_ff, state_in;
   logic [1:0]     chan_ff;
   logic [RPW-1:0] pix_ff, pix_in, pix_next;
   logic [7:0]     x_ff, x_in;
   logic           last_ff, last_in;
   logic           phase_ff, phase_in;
   logic [7:0]     rv_ff, rv_in;
   logic [6:0]     rc_ff, rc_in;
   logic [6:0]     lc_ff, lc_in;
   logic [7:0]     ra_ff, ra_in, rb_ff, rb_in;
   logic [1:0]     rn_ff, rn_in;
   logic [7:0]     list_ff [5];
   logic [7:0]     list_in [5];
   logic [2:0]     len_ff, len_in;
   logic [2:0]     lidx_ff, lidx_in;
   logic [6:0]     fcnt_ff, fcnt_in;
   logic [AW-1:0]  didx_ff, didx_in;
   logic           flush;
   logic           ram_we;
   logic [AW-1:0]  ram_waddr, ram_raddr;
   logic [7:0]     ram_wdata, ram_rdata;
   logic [15:0]    lum_sum;
   logic [7:0]     x_sel;
   logic           accept, push_ready, push_fire;
   rgbrle_pkg::byte_push_type push;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign lum_sum = 16'(rgbrle_pkg::LUMA_R) * 16'(req_red)
                  + 16'(rgbrle_pkg::LUMA_G) * 16'(req_green)
                  + 16'(rgbrle_pkg::LUMA_B) * 16'(req_blue);

   always_comb begin
      case (chan_ff)
         rgbrle_pkg::CH_RED:   x_sel = req_red;
         rgbrle_pkg::CH_GREEN: x_sel = req_green;
         rgbrle_pkg::CH_BLUE:  x_sel = req_blue;
         default:              x_sel = lum_sum[15:8];
      endcase
   end

   assign pix_next = pix_ff + RPW'(1);

   // Byte source for the packer.
   always_comb begin
      push = '0;
      case (state_ff)
         S_HDR: begin
            push.valid = 1'b1;
            push.data  = rgbrle_pkg::LIT_FLAG | {1'b0, fcnt_ff};
         end
         S_DATA: begin
            push.valid = 1'b1;
            push.data  = ram_rdata;
         end
         S_LIST: begin
            push.valid      = 1'b1;
            push.data       = list_ff[lidx_ff];
            push.final_byte = last_ff && (lidx_ff == len_ff - 3'd1);
         end
         default: push = '0;
      endcase
   end

   assign push_fire = push.valid && push_ready;

   // Read address: keep reissuing the current entry while stalled.
   always_comb begin
      if (state_ff == S_DATA && push_fire) begin
         ram_raddr = didx_ff + AW'(1);
      end else if (state_ff == S_DATA) begin
         ram_raddr = didx_ff;
      end else begin
         ram_raddr = '0;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pix_in    = pix_ff;
      x_in      = x_ff;
      last_in   = last_ff;
      phase_in  = phase_ff;
      rv_in     = rv_ff;
      rc_in     = rc_ff;
      lc_in     = lc_ff;
      ra_in     = ra_ff;
      rb_in     = rb_ff;
      rn_in     = rn_ff;
      list_in   = list_ff;
      len_in    = len_ff;
      lidx_in   = lidx_ff;
      fcnt_in   = fcnt_ff;
      didx_in   = didx_ff;
      flush     = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = lc_ff[AW-1:0];
      ram_wdata = ra_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_in    = x_sel;
               last_in = req_last_in_row || (pix_next >= RPW'(MAX_ROW_WIDTH));
               pix_in  = last_in ? '0 : pix_next;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            len_in  = 3'd0;
            lidx_in = 3'd0;
            didx_in = '0;
            if (phase_ff == PH_RUN) begin
               if (x_ff == rv_ff) begin
                  rc_in = rc_ff + 7'd1;
                  if (rc_in == CHUNK) begin
                     list_in[0] = 8'(CHUNK);
                     list_in[1] = rv_ff;
                     len_in     = 3'd2;
                     rc_in      = 7'd0;
                  end
               end else begin
                  if (rc_ff != 7'd0) begin
                     list_in[0] = {1'b0, rc_ff};
                     list_in[1] = rv_ff;
                     len_in     = 3'd2;
                  end
                  phase_in = PH_LITERAL;
                  rc_in    = 7'd0;
                  lc_in    = 7'd0;
                  ra_in    = x_ff;
                  rb_in    = 8'd0;
                  rn_in    = 2'd1;
               end
            end else if (rn_ff < 2'd2) begin
               if (rn_ff == 2'd0) begin
                  ra_in = x_ff;
               end else begin
                  rb_in = x_ff;
               end
               rn_in = rn_ff + 2'd1;
            end else if (ra_ff == rb_ff && rb_ff == x_ff) begin
               if (lc_ff != 7'd0) begin
                  flush   = 1'b1;
                  fcnt_in = lc_ff;
               end
               lc_in    = 7'd0;
               phase_in = PH_RUN;
               rv_in    = ra_ff;
               rc_in    = 7'd3;
               ra_in    = 8'd0;
               rb_in    = 8'd0;
               rn_in    = 2'd0;
            end else begin
               ram_we = 1'b1;
               lc_in  = lc_ff + 7'd1;
               if (lc_in == CHUNK) begin
                  flush   = 1'b1;
                  fcnt_in = CHUNK;
                  lc_in   = 7'd0;
               end
               ra_in = rb_ff;
               rb_in = x_ff;
            end
            if (last_ff) begin
               if (phase_in == PH_LITERAL) begin
                  if (lc_in != 7'd0) begin
                     flush   = 1'b1;
                     fcnt_in = lc_in;
                  end
                  if (rn_in == 2'd2 && ra_in == rb_in) begin
                     list_in[len_in]        = 8'd2;
                     list_in[len_in + 3'd1] = ra_in;
                     len_in                 = len_in + 3'd2;
                  end else if (rn_in == 2'd2) begin
                     list_in[len_in]        = 8'd1;
                     list_in[len_in + 3'd1] = ra_in;
                     list_in[len_in + 3'd2] = 8'd1;
                     list_in[len_in + 3'd3] = rb_in;
                     len_in                 = len_in + 3'd4;
                  end else if (rn_in == 2'd1) begin
                     list_in[len_in]        = 8'd1;
                     list_in[len_in + 3'd1] = ra_in;
                     len_in                 = len_in + 3'd2;
                  end
               end else if (rc_in != 7'd0) begin
                  list_in[len_in]        = {1'b0, rc_in};
                  list_in[len_in + 3'd1] = rv_in;
                  len_in                 = len_in + 3'd2;
               end
               list_in[len_in] = 8'd0;
               len_in          = len_in + 3'd1;
               phase_in = PH_LITERAL;
               rv_in    = 8'd0;
               rc_in    = 7'd0;
               lc_in    = 7'd0;
               ra_in    = 8'd0;
               rb_in    = 8'd0;
               rn_in    = 2'd0;
            end
            if (flush) begin
               state_in = S_HDR;
            end else if (len_in != 3'd0) begin
               state_in = S_LIST;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_HDR: begin
            if (push_fire) begin
               state_in = S_DATA;
            end
         end
         S_DATA: begin
            if (push_fire) begin
               didx_in = didx_ff + AW'(1);
               if ({1'b0, didx_ff} == 8'(fcnt_ff) - 8'd1) begin
                  state_in = (len_ff != 3'd0) ? S_LIST : S_IDLE;
               end
            end
         end
         S_LIST: begin
            if (push_fire) begin
               lidx_in = lidx_ff + 3'd1;
               if (lidx_ff == len_ff - 3'd1) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         chan_ff  <= rgbrle_pkg::CH_RED;
         pix_ff   <= '0;
         phase_ff <= PH_LITERAL;
         rv_ff    <= '0;
         rc_ff    <= '0;
         lc_ff    <= '0;
         ra_ff    <= '0;
         rb_ff    <= '0;
         rn_ff    <= '0;
         len_ff   <= '0;
         lidx_ff  <= '0;
         didx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            chan_ff <= csr_wr_data;
         end
         pix_ff   <= pix_in;
         phase_ff <= phase_in;
         rv_ff    <= rv_in;
         rc_ff    <= rc_in;
         lc_ff    <= lc_in;
         ra_ff    <= ra_in;
         rb_ff    <= rb_in;
         rn_ff    <= rn_in;
         len_ff   <= len_in;
         lidx_ff  <= lidx_in;
         didx_ff  <= didx_in;
      end
      x_ff    <= x_in;
      last_ff <= last_in;
      list_ff <= list_in;
      fcnt_ff <= fcnt_in;
   end

   rgbrle_ram #(
      .WIDTH(8),
      .DEPTH(rgbrle_pkg::STORE_DEPTH)
   ) u_literal_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   rgbrle_packer #(
      .WORD_BYTES(WORD_BYTES)
   ) u_packer (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .push_ready    (push_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_word  (rsp_out_word),
      .rsp_out_bytes (rsp_out_bytes),
      .rsp_row_end   (rsp_row_end),
      .rsp_row_bytes (rsp_row_bytes)
   );

   `RLE_ASSERT(a_bytes_range, clock, reset, rsp_valid |-> (rsp_out_bytes != 4'd0 && rsp_out_bytes <= 4'(WORD_BYTES)))
   `RLE_ASSERT(a_data_idx, clock, reset, (state_ff == S_DATA) |-> ({1'b0, didx_ff} < 8'(fcnt_ff)))
   `RLE_ASSERT(a_lit_bound, clock, reset, (state_ff == S_IDLE) |-> (lc_ff < CHUNK))
   `RLE_ASSERT_NEVER(a_run_and_recent, clock, reset, phase_ff == PH_RUN && rn_ff != 2'd0)
endmodule

FILE: rtl/rgbrle_ram.sv
// Generic single-port-write, registered-read RAM.
module rgbrle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/rgbrle_packer.sv
// Byte packer: collects encoded bytes into words and holds the output register.
module rgbrle_packer #(
   parameter int WORD_BYTES = rgbrle_pkg::DEFAULT_WORD_BYTES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rgbrle_pkg::byte_push_type  push,
   output logic                       push_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [63:0]                rsp_out_word,
   output logic [3:0]                 rsp_out_bytes,
   output logic                       rsp_row_end,
   output logic [17:0]                rsp_row_bytes
);
   localparam int FW = $clog2(WORD_BYTES + 1);

   logic [8*WORD_BYTES-1:0] word_ff, word_in, word_put;
   logic [FW-1:0]           fill_ff, fill_in;
   logic [17:0]             total_ff, total_in, total_put;
   logic                    valid_ff, valid_in;
   logic [63:0]             out_word_ff, out_word_in;
   logic [3:0]              out_bytes_ff, out_bytes_in;
   logic                    row_end_ff, row_end_in;
   logic [17:0]             row_bytes_ff, row_bytes_in;
   logic                    completes, fire;

   always_comb begin
      word_put = word_ff;
      for (int i = 0; i < WORD_BYTES; i++) begin
         if (fill_ff == FW'(i)) begin
            word_put[8*i +: 8] = push.data;
         end
      end
   end

   assign completes  = (fill_ff == FW'(WORD_BYTES - 1)) || push.final_byte;
   assign push_ready = !completes || !valid_ff || rsp_ready;
   assign fire       = push.valid && push_ready;
   assign total_put  = (total_ff == rgbrle_pkg::TOTAL_MAX) ? total_ff : total_ff + 18'd1;

   always_comb begin
      word_in      = word_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      valid_in     = valid_ff && !rsp_ready;
      out_word_in  = out_word_ff;
      out_bytes_in = out_bytes_ff;
      row_end_in   = row_end_ff;
      row_bytes_in = row_bytes_ff;
      if (fire) begin
         total_in = push.final_byte ? 18'd0 : total_put;
         if (completes) begin
            word_in      = '0;
            fill_in      = '0;
            valid_in     = 1'b1;
            out_word_in  = 64'(word_put);
            out_bytes_in = 4'(fill_ff) + 4'd1;
            row_end_in   = push.final_byte;
            row_bytes_in = push.final_byte ? total_put : 18'd0;
         end else begin
            word_in = word_put;
            fill_in = fill_ff + FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff  <= '0;
         fill_ff  <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         word_ff  <= word_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         valid_ff <= valid_in;
      end
      out_word_ff  <= out_word_in;
      out_bytes_ff <= out_bytes_in;
      row_end_ff   <= row_end_in;
      row_bytes_ff <= row_bytes_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_word  = out_word_ff;
   assign rsp_out_bytes = out_bytes_ff;
   assign rsp_row_end   = row_end_ff;
   assign rsp_row_bytes = row_bytes_ff;
endmodule
